[hdl/rhc_pkg.sv]
// Shared constants, types and the divider step for the RGB to HSV converter.
`default_nettype none

package rhc_pkg;

	localparam int CHANNEL_BITS = 8;
	localparam logic [CHANNEL_BITS-1:0] CHAN_FULL = '1;

	// Hue is degrees times 64: one sector of 60 degrees is 3840, a full turn 23040
	localparam int HUE_W      = 15;
	localparam int HUE_SECTOR = 3840;
	localparam int HUE_FULL   = 23040;
	localparam int HUE_Q_BITS = 12;
	localparam int HUE_CALC_W = HUE_W + 2;

	// Restoring divider: quotient bits must cover both the hue fraction and saturation
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_QW_MIN = (CHANNEL_BITS > HUE_Q_BITS) ? CHANNEL_BITS : HUE_Q_BITS;
	localparam int DIV_QW = ((DIV_QW_MIN + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE)
		* DIV_BITS_PER_STAGE;
	localparam int DIV_NW     = DIV_QW + CHANNEL_BITS;
	localparam int DIV_STAGES = DIV_QW / DIV_BITS_PER_STAGE;
	localparam int DIV_LANES  = 2;
	localparam int LANE_SAT   = 0;
	localparam int LANE_HUE   = 1;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// One division in flight: partial remainder, dividend bits shifting out
	// at the top while quotient bits shift in at the bottom, and the divisor
	typedef struct packed {
		logic [CHANNEL_BITS-1:0] rem;
		logic [DIV_QW-1:0]       work;
		logic [CHANNEL_BITS-1:0] dvs;
	} lane_t;

	// Per-item control that rides alongside the divider
	typedef struct packed {
		sector_t                 sector;
		logic                    neg;
		logic                    mx_zero;
		logic                    span_zero;
		logic [CHANNEL_BITS-1:0] mx;
	} side_t;

	function automatic lane_t div_step(lane_t l_in);
		lane_t l;
		logic [CHANNEL_BITS:0] t;
		l = l_in;
		for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
			t = {l.rem, l.work[DIV_QW-1]};
			l.work = {l.work[DIV_QW-2:0], 1'b0};
			if (t >= {1'b0, l.dvs}) begin
				t = t - {1'b0, l.dvs};
				l.work[0] = 1'b1;
			end
			l.rem = t[CHANNEL_BITS-1:0];
		end
		return l;
	endfunction

endpackage

`default_nettype wire

[hdl/rhc_front.sv]
// Front end: max/min, hue sector, difference, and dividend set-up (stages s1, s2).
`default_nettype none

module rhc_front import rhc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    in_vld,
	input  wire logic [CHANNEL_BITS-1:0] red,
	input  wire logic [CHANNEL_BITS-1:0] green,
	input  wire logic [CHANNEL_BITS-1:0] blue,
	output logic                         out_vld,
	output side_t                        side_out,
	output lane_t                        sat_lane,
	output lane_t                        hue_lane
);

	logic [CHANNEL_BITS-1:0] mx_c, mn_c, a_c, b_c, dabs_c;
	sector_t                 sector_c;
	logic                    neg_c;

	logic                    vld_s1;
	logic [CHANNEL_BITS-1:0] mx_s1, span_s1, dabs_s1;
	sector_t                 sector_s1;
	logic                    neg_s1;

	logic [DIV_NW-1:0] sat_num, hue_num;

	logic  vld_s2;
	side_t side_s2;
	lane_t sat_lane_s2, hue_lane_s2;

	always_comb begin
		mx_c = red;
		if (green > mx_c) mx_c = green;
		if (blue > mx_c) mx_c = blue;
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;

		// ties go to red, then green
		if (red == mx_c) begin
			sector_c = SEC_RED;
			a_c = green;
			b_c = blue;
		end else if (green == mx_c) begin
			sector_c = SEC_GREEN;
			a_c = blue;
			b_c = red;
		end else begin
			sector_c = SEC_BLUE;
			a_c = red;
			b_c = green;
		end
		neg_c  = (a_c < b_c);
		dabs_c = neg_c ? (b_c - a_c) : (a_c - b_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mx_s1     <= mx_c;
			span_s1   <= mx_c - mn_c;
			dabs_s1   <= dabs_c;
			sector_s1 <= sector_c;
			neg_s1    <= neg_c;
		end
	end

	assign sat_num = DIV_NW'(span_s1) * DIV_NW'(CHAN_FULL);
	assign hue_num = DIV_NW'(dabs_s1) * DIV_NW'(HUE_SECTOR);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.sector    <= sector_s1;
			side_s2.neg       <= neg_s1;
			side_s2.mx_zero   <= (mx_s1 == '0);
			side_s2.span_zero <= (span_s1 == '0);
			side_s2.mx        <= mx_s1;

			sat_lane_s2.rem  <= sat_num[DIV_NW-1 -: CHANNEL_BITS];
			sat_lane_s2.work <= sat_num[DIV_QW-1:0];
			sat_lane_s2.dvs  <= mx_s1;

			hue_lane_s2.rem  <= hue_num[DIV_NW-1 -: CHANNEL_BITS];
			hue_lane_s2.work <= hue_num[DIV_QW-1:0];
			hue_lane_s2.dvs  <= span_s1;
		end
	end

	assign out_vld  = vld_s2;
	assign side_out = side_s2;
	assign sat_lane = sat_lane_s2;
	assign hue_lane = hue_lane_s2;

endmodule

`default_nettype wire

[hdl/rhc_div.sv]
// Pipelined restoring divider, two lanes (saturation, hue fraction), two bits per stage.
`default_nettype none

module rhc_div import rhc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  in_vld,
	input  wire side_t side_in,
	input  wire lane_t sat_lane,
	input  wire lane_t hue_lane,
	output logic              out_vld,
	output side_t             side_out,
	output logic [DIV_QW-1:0] sat_quo,
	output logic [DIV_QW-1:0] hue_quo
);

	logic  vld_q  [DIV_STAGES];
	side_t side_q [DIV_STAGES];
	lane_t lane_q [DIV_STAGES][DIV_LANES];
	lane_t lane_in [DIV_LANES];

	assign lane_in[LANE_SAT] = sat_lane;
	assign lane_in[LANE_HUE] = hue_lane;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < DIV_STAGES; s++) begin
				vld_q[s] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= in_vld;
			for (int s = 1; s < DIV_STAGES; s++) begin
				vld_q[s] <= vld_q[s-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_in;
			for (int l = 0; l < DIV_LANES; l++) begin
				lane_q[0][l] <= div_step(lane_in[l]);
			end
			for (int s = 1; s < DIV_STAGES; s++) begin
				side_q[s] <= side_q[s-1];
				for (int l = 0; l < DIV_LANES; l++) begin
					lane_q[s][l] <= div_step(lane_q[s-1][l]);
				end
			end
		end
	end

	assign out_vld  = vld_q[DIV_STAGES-1];
	assign side_out = side_q[DIV_STAGES-1];
	assign sat_quo  = lane_q[DIV_STAGES-1][LANE_SAT].work;
	assign hue_quo  = lane_q[DIV_STAGES-1][LANE_HUE].work;

	// the last stage's valid, side data and hue quotient hold while the pipeline is frozen
	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && !adv |=> out_vld && $stable(side_out) && $stable(hue_quo))
		else $error("divider last stage changed while frozen");

endmodule

`default_nettype wire

[hdl/rhc_back.sv]
// Back end: hue assembly from sector and quotient, output register.
`default_nettype none

module rhc_back import rhc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_vld,
	input  wire side_t             side_in,
	input  wire logic [DIV_QW-1:0] sat_quo,
	input  wire logic [DIV_QW-1:0] hue_quo,
	output logic                    out_vld,
	output logic [HUE_W-1:0]        hue,
	output logic [CHANNEL_BITS-1:0] saturation,
	output logic [CHANNEL_BITS-1:0] brightness
);

	logic signed [HUE_CALC_W-1:0] base_v, q_v, h_v;
	logic [HUE_W-1:0]             hue_d;
	logic [CHANNEL_BITS-1:0]      sat_d;

	logic                    vld_q;
	logic [HUE_W-1:0]        hue_q;
	logic [CHANNEL_BITS-1:0] sat_q, bright_q;

	always_comb begin
		case (side_in.sector)
			SEC_RED:   base_v = '0;
			SEC_GREEN: base_v = HUE_CALC_W'(2 * HUE_SECTOR);
			SEC_BLUE:  base_v = HUE_CALC_W'(4 * HUE_SECTOR);
			default:   base_v = '0;
		endcase
		q_v = HUE_CALC_W'(hue_quo[HUE_Q_BITS-1:0]);
		h_v = side_in.neg ? (base_v - q_v) : (base_v + q_v);
		// wrap a negative red-sector hue into the full turn
		if (h_v < 0) h_v = h_v + HUE_CALC_W'(HUE_FULL);
		hue_d = side_in.span_zero ? '0 : h_v[HUE_W-1:0];
		sat_d = side_in.mx_zero ? '0 : sat_quo[CHANNEL_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_q    <= hue_d;
			sat_q    <= sat_d;
			bright_q <= side_in.mx;
		end
	end

	assign out_vld    = vld_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = bright_q;

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> hue < HUE_W'(HUE_FULL))
		else $error("hue out of range");

	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && saturation == '0 |-> hue == '0)
		else $error("unsaturated pixel with nonzero hue");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld && brightness == '0 |-> saturation == '0)
		else $error("black pixel with nonzero saturation");

endmodule

`default_nettype wire

[hdl/rgb_to_hsv_converter_top.sv]
// Top level of the RGB to HSV converter: front end, divider pipeline, back end.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   input   | in        | in_valid/in_stall  | red, green, blue
//   output  | out       | out_valid/out_stall| hue, saturation, brightness
//
// One item per cycle sustained while the output is not stalled. The pipeline is
// two front stages, the divider at two quotient bits per stage, and the output
// register.
// Reset clears only the valid bits; the pipeline is empty after reset.
// A stall on the output freezes every stage while the output holds an item;
// in_stall follows from it in the same cycle.
`default_nettype none

module rgb_to_hsv_converter_top import rhc_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [CHANNEL_BITS-1:0] red,
	input  wire logic [CHANNEL_BITS-1:0] green,
	input  wire logic [CHANNEL_BITS-1:0] blue,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [HUE_W-1:0]             hue,
	output logic [CHANNEL_BITS-1:0]      saturation,
	output logic [CHANNEL_BITS-1:0]      brightness
);

	logic adv;

	logic  fr_vld;
	side_t fr_side;
	lane_t fr_sat_lane, fr_hue_lane;

	logic              dv_vld;
	side_t             dv_side;
	logic [DIV_QW-1:0] dv_sat_quo, dv_hue_quo;

	// advance whenever the output register is free or being taken
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	rhc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (in_valid),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.out_vld  (fr_vld),
		.side_out (fr_side),
		.sat_lane (fr_sat_lane),
		.hue_lane (fr_hue_lane)
	);

	rhc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (fr_vld),
		.side_in  (fr_side),
		.sat_lane (fr_sat_lane),
		.hue_lane (fr_hue_lane),
		.out_vld  (dv_vld),
		.side_out (dv_side),
		.sat_quo  (dv_sat_quo),
		.hue_quo  (dv_hue_quo)
	);

	rhc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_vld     (dv_vld),
		.side_in    (dv_side),
		.sat_quo    (dv_sat_quo),
		.hue_quo    (dv_hue_quo),
		.out_vld    (out_valid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule

`default_nettype wire
